// ----- sv/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is low.
`define RFFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising edge, quiet while reset is low.
`define RFFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/rffp_pkg.sv -----
package rffp_pkg;

    localparam int unsigned PAYLOAD_LIMIT_DEF = 32;
    localparam logic [7:0]  HEADER_BYTE       = 8'hEF;
    localparam logic [7:0]  DEVICE_ID_RESET   = 8'h0F;

    // Frame offsets
    localparam int unsigned OFS_ID     = 1;
    localparam int unsigned OFS_LEN    = 5;
    localparam int unsigned OFS_PAY    = 6;
    localparam int unsigned OFS_DIST0  = 10;
    localparam int unsigned OFS_DIST1  = 11;
    localparam int unsigned OFS_DIST2  = 12;
    localparam int unsigned OFS_DIST3  = 13;
    localparam int unsigned OFS_STR    = 14;
    localparam int unsigned OFS_RVALID = 16;
    localparam int unsigned OFS_FX0    = 18;
    localparam int unsigned OFS_FX1    = 19;
    localparam int unsigned OFS_FY0    = 20;
    localparam int unsigned OFS_FY1    = 21;
    localparam int unsigned OFS_QUAL   = 22;
    localparam int unsigned OFS_FVALID = 23;

    typedef enum logic [2:0] {
        ST_IN_PROGRESS = 3'd0,
        ST_FRAME_OK    = 3'd1,
        ST_NO_HEADER   = 3'd2,
        ST_BAD_ID      = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_BAD_CSUM    = 3'd5
    } t_status;

    // Packed from the lowest bit up: status first.
    typedef struct packed {
        logic        [7:0]  flow_valid;
        logic        [7:0]  flow_quality;
        logic signed [15:0] flow_y;
        logic signed [15:0] flow_x;
        logic        [7:0]  range_valid;
        logic        [7:0]  signal_strength;
        logic        [31:0] distance_mm;
        t_status            status;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);
    localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- sv/rffp_core.sv -----
module rffp_core
    import rffp_pkg::*;
#(
    parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_device_id,
    output t_result    o_result
);

    localparam int unsigned LEN_W = $clog2(PAYLOAD_LIMIT);
    localparam int unsigned CNT_W = $clog2(PAYLOAD_LIMIT + 7);

    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_id,    n_id;
    logic [31:0]      r_dist,  n_dist;
    logic [7:0]       r_str,   n_str;
    logic [7:0]       r_rval,  n_rval;
    logic [15:0]      r_fx,    n_fx;
    logic [15:0]      r_fy,    n_fy;
    logic [7:0]       r_qual,  n_qual;
    logic [7:0]       r_fval,  n_fval;
    t_status          status;
    logic [CNT_W-1:0] last_pos;

    assign last_pos = CNT_W'(OFS_PAY) + CNT_W'(r_len);

    always_comb begin
        n_cnt  = r_cnt;
        n_len  = r_len;
        n_sum  = r_sum;
        n_id   = r_id;
        n_dist = r_dist;
        n_str  = r_str;
        n_rval = r_rval;
        n_fx   = r_fx;
        n_fy   = r_fy;
        n_qual = r_qual;
        n_fval = r_fval;
        status = ST_IN_PROGRESS;

        if (r_cnt == '0) begin
            if (i_rx_byte != HEADER_BYTE) begin
                status = ST_NO_HEADER;
            end else begin
                n_sum = i_rx_byte;
                n_cnt = CNT_W'(1);
            end
        end else begin
            // latch mapped offsets, also for frames that fail later
            case (r_cnt)
                CNT_W'(OFS_ID):     n_id          = i_rx_byte;
                CNT_W'(OFS_DIST0):  n_dist[7:0]   = i_rx_byte;
                CNT_W'(OFS_DIST1):  n_dist[15:8]  = i_rx_byte;
                CNT_W'(OFS_DIST2):  n_dist[23:16] = i_rx_byte;
                CNT_W'(OFS_DIST3):  n_dist[31:24] = i_rx_byte;
                CNT_W'(OFS_STR):    n_str         = i_rx_byte;
                CNT_W'(OFS_RVALID): n_rval        = i_rx_byte;
                CNT_W'(OFS_FX0):    n_fx[7:0]     = i_rx_byte;
                CNT_W'(OFS_FX1):    n_fx[15:8]    = i_rx_byte;
                CNT_W'(OFS_FY0):    n_fy[7:0]     = i_rx_byte;
                CNT_W'(OFS_FY1):    n_fy[15:8]    = i_rx_byte;
                CNT_W'(OFS_QUAL):   n_qual        = i_rx_byte;
                CNT_W'(OFS_FVALID): n_fval        = i_rx_byte;
                default: ;
            endcase

            if (r_cnt == CNT_W'(OFS_LEN)) begin
                if (r_id != i_device_id) begin
                    status = ST_BAD_ID;
                    n_cnt  = '0;
                end else if ({1'b0, i_rx_byte} >= 9'(PAYLOAD_LIMIT)) begin
                    status = ST_BAD_LENGTH;
                    n_cnt  = '0;
                end else begin
                    n_len = i_rx_byte[LEN_W-1:0];
                    n_sum = r_sum + i_rx_byte;
                    n_cnt = CNT_W'(OFS_PAY);
                end
            end else if (r_cnt >= CNT_W'(OFS_PAY) && r_cnt == last_pos) begin
                n_cnt  = '0;
                status = (r_sum == i_rx_byte) ? ST_FRAME_OK : ST_BAD_CSUM;
            end else begin
                n_sum = r_sum + i_rx_byte;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end

        o_result        = '0;
        o_result.status = status;
        if (status == ST_FRAME_OK) begin
            o_result.distance_mm     = n_dist;
            o_result.signal_strength = n_str;
            o_result.range_valid     = n_rval;
            o_result.flow_x          = n_fx;
            o_result.flow_y          = n_fy;
            o_result.flow_quality    = n_qual;
            o_result.flow_valid      = n_fval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_len  <= '0;
            r_sum  <= '0;
            r_id   <= '0;
            r_dist <= '0;
            r_str  <= '0;
            r_rval <= '0;
            r_fx   <= '0;
            r_fy   <= '0;
            r_qual <= '0;
            r_fval <= '0;
        end else if (i_advance) begin
            r_cnt  <= n_cnt;
            r_len  <= n_len;
            r_sum  <= n_sum;
            r_id   <= n_id;
            r_dist <= n_dist;
            r_str  <= n_str;
            r_rval <= n_rval;
            r_fx   <= n_fx;
            r_fy   <= n_fy;
            r_qual <= n_qual;
            r_fval <= n_fval;
        end
    end

endmodule

// ----- sv/range_flow_frame_parser.sv -----
// Range and optical-flow frame parser. Feed one received serial byte per
// input transaction; every byte yields exactly one result transaction. A
// frame opens with 0xEF, carries the device id at offset 1 and the payload
// length at offset 5 (must stay below PAYLOAD_LIMIT), and closes with an
// 8-bit additive checksum of all bytes before it, 7 + length bytes in all.
// The result status reads 0 while a frame is in progress, 1 for a good
// frame (data fields then carry distance, strength, flow and validity
// bytes), 2 for a stray byte outside a frame, 3 for a wrong id, 4 for a
// length that is too large and 5 for a bad checksum; data fields are zero
// unless the status is 1. Fields at offsets a short frame does not reach
// keep values captured from earlier frames. Throughput is one byte per
// clock while the output is not stalled: the parse state and the output
// register both update at the accepting edge, so each result is offered
// the cycle after its byte; while the output is stalled, a one-entry skid
// register takes one more result, then the input waits until the output
// drains. Write the device id only while the stream is idle.
`include "assert_macros.svh"

module range_flow_frame_parser
    import rffp_pkg::*;
#(
    parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: device id
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    // byte stream in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    // results out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [2:0] status, [34:3] distance_mm, [42:35] signal_strength,
    // [50:43] range_valid, [66:51] flow_x, [82:67] flow_y,
    // [90:83] flow_quality, [98:91] flow_valid, rest zero
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic [7:0] r_device_id;
    logic       in_acc;
    logic       out_pop;
    t_result    new_result;
    t_result    r_out,  r_skid;
    logic       r_out_valid, r_skid_valid;

    // Hold the device id; no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= DEVICE_ID_RESET;
        end else if (i_cfg_wr_en) begin
            r_device_id <= i_cfg_wr_data;
        end
    end

    // Stall input only while the skid register is occupied.
    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;

    rffp_core #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (in_acc),
        .i_rx_byte   (s_axis_tdata),
        .i_device_id (r_device_id),
        .o_result    (new_result)
    );

    // Control: output register plus one skid entry, kept in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled; advance the skid entry when the output drains
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_pop) begin
                r_skid <= new_result;
            end else begin
                r_out <= new_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);

    // A skid entry never sits behind an empty output register.
    `RFFP_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held while output register is empty")

    // Distance and flow fields stay zero unless the frame checked out.
    `RFFP_ASSERT_IMP(a_zero_fields, i_clk, i_rst_n,
        r_out_valid && r_out.status != ST_FRAME_OK,
        r_out.distance_mm == '0 && r_out.flow_x == '0 && r_out.flow_y == '0,
        "data fields set on a result that is not a good frame")

    // Input stalls only after a result was held back at the output.
    `RFFP_ASSERT(a_stall_cause, i_clk, i_rst_n,
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready),
        "input stalled without a blocked output")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

import rffp_pkg::*;

typedef bit [7:0] byte_q_t[$];

// Tracks the parser state on every accepted byte and holds the per-byte
// reports the block is expected to produce, oldest first.
class frame_scoreboard;
    bit [7:0]  device_id;
    bit [5:0]  byte_count;
    bit [4:0]  payload_length;
    bit [7:0]  running_sum;
    bit [7:0]  id_seen;
    bit [31:0] distance;
    bit [7:0]  strength;
    bit [7:0]  range_ok;
    bit [15:0] flow_x;
    bit [15:0] flow_y;
    bit [7:0]  quality;
    bit [7:0]  flow_ok;
    t_result   byte_reports[$];
    int        errors;

    function new();
        device_id      = DEVICE_ID_RESET;
        byte_count     = '0;
        payload_length = '0;
        running_sum    = '0;
        id_seen        = '0;
        distance       = '0;
        strength       = '0;
        range_ok       = '0;
        flow_x         = '0;
        flow_y         = '0;
        quality        = '0;
        flow_ok        = '0;
        errors         = 0;
    endfunction

    function int pending();
        return byte_reports.size();
    endfunction

    function void note_byte(bit [7:0] b);
        t_result     r;
        int unsigned pos;
        r        = '0;
        r.status = ST_IN_PROGRESS;
        if (byte_count == 0) begin
            if (b != HEADER_BYTE) begin
                r.status = ST_NO_HEADER;
            end else begin
                running_sum = b;
                byte_count  = 6'd1;
            end
        end else begin
            pos = byte_count;
            case (pos)
                OFS_ID:     id_seen         = b;
                OFS_DIST0:  distance[7:0]   = b;
                OFS_DIST1:  distance[15:8]  = b;
                OFS_DIST2:  distance[23:16] = b;
                OFS_DIST3:  distance[31:24] = b;
                OFS_STR:    strength        = b;
                OFS_RVALID: range_ok        = b;
                OFS_FX0:    flow_x[7:0]     = b;
                OFS_FX1:    flow_x[15:8]    = b;
                OFS_FY0:    flow_y[7:0]     = b;
                OFS_FY1:    flow_y[15:8]    = b;
                OFS_QUAL:   quality         = b;
                OFS_FVALID: flow_ok         = b;
                default: ;
            endcase
            if (pos == OFS_LEN) begin
                if (id_seen != device_id) begin
                    r.status   = ST_BAD_ID;
                    byte_count = '0;
                end else if (b >= PAYLOAD_LIMIT_DEF) begin
                    r.status   = ST_BAD_LENGTH;
                    byte_count = '0;
                end else begin
                    payload_length = b[4:0];
                    running_sum    = running_sum + b;
                    byte_count     = 6'(OFS_PAY);
                end
            end else if (pos >= OFS_PAY && pos == OFS_PAY + payload_length) begin
                byte_count = '0;
                if (running_sum != b) begin
                    r.status = ST_BAD_CSUM;
                end else begin
                    r.status          = ST_FRAME_OK;
                    r.distance_mm     = distance;
                    r.signal_strength = strength;
                    r.range_valid     = range_ok;
                    r.flow_x          = flow_x;
                    r.flow_y          = flow_y;
                    r.flow_quality    = quality;
                    r.flow_valid      = flow_ok;
                end
            end else begin
                running_sum = running_sum + b;
                byte_count  = byte_count + 6'd1;
            end
        end
        byte_reports.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
    endfunction

    function void check_report(logic [TDATA_W-1:0] data);
        t_result got;
        t_result want;
        got = t_result'(data[RESULT_W-1:0]);
        if (byte_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, data);
        end else begin
            want = byte_reports.pop_front();
            compare_field("status",          want.status,          got.status);
            compare_field("distance_mm",     want.distance_mm,     got.distance_mm);
            compare_field("signal_strength", want.signal_strength, got.signal_strength);
            compare_field("range_valid",     want.range_valid,     got.range_valid);
            compare_field("flow_x",          16'(want.flow_x),     16'(got.flow_x));
            compare_field("flow_y",          16'(want.flow_y),     16'(got.flow_y));
            compare_field("flow_quality",    want.flow_quality,    got.flow_quality);
            compare_field("flow_valid",      want.flow_valid,      got.flow_valid);
        end
    endfunction
endclass

module tb_top;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BYTES  = 260;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [7:0]         i_cfg_wr_data = DEVICE_ID_RESET;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    // Idle rates for the current phase, changed only between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_bytes    = 0;

    // Long receiver hold-off: the main flow bumps the request count, the
    // receiver process counts the stall out on its own.
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    frame_scoreboard board;

    range_flow_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on every accepted byte, check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_report(m_axis_tdata);
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it
    // until the transaction completes.
    task automatic send_byte(input bit [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_bytes++;
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Write the device id; only call while the stream is idle.
    task automatic write_device_id(input bit [7:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        board.device_id = value;
    endtask

    // Assemble header, id, three filler bytes, length, payload and checksum.
    // A length at or above the limit ends the frame after the length byte.
    function automatic byte_q_t build_frame(bit [7:0] id, bit [7:0] len, bit csum_good);
        byte_q_t  q;
        bit [7:0] sum;
        q.push_back(HEADER_BYTE);
        q.push_back(id);
        repeat (3) q.push_back(8'($urandom));
        q.push_back(len);
        if (len < PAYLOAD_LIMIT_DEF) begin
            repeat (len) q.push_back(8'($urandom));
            sum = '0;
            foreach (q[i]) sum += q[i];
            q.push_back(csum_good ? sum : sum ^ 8'($urandom_range(1, 255)));
        end
        return q;
    endfunction

    function automatic bit [7:0] pick_length();
        return $urandom_range(1) ? 8'($urandom_range(17, 31)) : 8'($urandom_range(0, 31));
    endfunction

    // One random phase: mostly well-formed frames with random content, the
    // rest stray bytes, wrong ids, oversize lengths, truncated frames and bad checksums.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input bit pressure);
        byte_q_t     frame;
        int unsigned kind;
        bit          hold_sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_bytes    = 0;
        hold_sent      = 1'b0;
        while (phase_bytes < PHASE_BYTES) begin
            if (pressure && !hold_sent && phase_bytes > 30) begin
                hold_req  <= hold_req + 1;
                hold_sent  = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 8) begin
                frame = {8'($urandom)};
            end else if (kind < 13) begin
                frame = build_frame(board.device_id ^ 8'($urandom_range(1, 255)),
                                    8'($urandom), 1'b1);
                frame = frame[0:5];
            end else if (kind < 18) begin
                frame = build_frame(board.device_id, 8'($urandom_range(32, 255)), 1'b1);
            end else if (kind < 23) begin
                frame = build_frame(board.device_id, pick_length(), 1'b1);
                frame = frame[0:$urandom_range(1, frame.size() - 2)];
            end else begin
                frame = build_frame(board.device_id, pick_length(), $urandom_range(99) < 88);
            end
            send_bytes(frame);
        end
        drain_results();
    endtask

    initial begin
        byte_q_t q;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stray bytes at both extremes, then good, wrong-id
        // (with an oversize length as well, id check wins), oversize and
        // bad-checksum frames at the reset device id.
        q = {8'h00, 8'hFF};
        send_bytes(q);
        send_bytes(build_frame(DEVICE_ID_RESET, 8'd0, 1'b1));
        send_bytes(build_frame(DEVICE_ID_RESET ^ 8'h01, 8'hFF, 1'b1));
        send_bytes(build_frame(DEVICE_ID_RESET, 8'd32, 1'b1));
        send_bytes(build_frame(DEVICE_ID_RESET, 8'd0, 1'b0));
        drain_results();

        // Random phases across device ids and idle patterns.
        write_device_id(8'h00);
        run_phase(0, 0, 1'b0);
        write_device_id(8'hFF);
        run_phase(57, 0, 1'b0);
        write_device_id(8'($urandom));
        run_phase(0, 57, 1'b0);
        write_device_id(HEADER_BYTE);
        run_phase(6, 6, 1'b0);
        write_device_id(8'($urandom));
        run_phase(0, 0, 1'b1);

        // Let the output pipeline settle before the verdict.
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("** range_flow_frame_parser: PASSED **");
        end else begin
            $display("** range_flow_frame_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("** range_flow_frame_parser: FAILED **");
        $finish;
    end

endmodule

// ----- range_flow_frame_parser.f -----
+incdir+sv
sv/rffp_pkg.sv
sv/rffp_core.sv
sv/range_flow_frame_parser.sv
bench/tb_top.sv
